// ----- rtl/core/jtp_pkg.sv -----
// shared types and constants for the johnson-trotter permutation step block
package jtp_pkg;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // register decode: paddr bit 2 selects the word, active_length at word 0
    localparam logic REG_ACTIVE_LENGTH = 1'b0;
    localparam logic [3:0] ACTIVE_LENGTH_RESET = 4'd8;

    // input item as it arrives on the command channel
    typedef struct packed {
        logic       func;
        logic [2:0] position;
        logic [7:0] elem_value;
        logic       arrow_right;
    } t_in_item;

    // one reported position of the permutation
    typedef struct packed {
        logic [2:0] out_position;
        logic [7:0] out_value;
        logic       out_arrow_right;
        logic       moved;
        logic       mobile_remains;
        logic       last;
    } t_out_item;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic update;
        logic active;
        logic active_right;
        logic has_left;
    } t_cell_cmd;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_PRE,
        ST_SWAP,
        ST_SCAN_POST,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/core/jtp_cell.sv -----
// one position of the permutation chain: value, arrow and a stage of the mobile scan
module jtp_cell #(
    parameter int VALUE_BITS = 8,
    parameter int POS_BITS   = 3,
    parameter int CELL_INDEX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jtp_pkg::t_cell_cmd    i_cmd,
    input  logic [VALUE_BITS-1:0] i_load_val,
    input  logic                  i_load_arrow,
    input  logic [VALUE_BITS-1:0] i_left_val,
    input  logic                  i_left_arrow,
    input  logic [VALUE_BITS-1:0] i_right_val,
    input  logic                  i_right_arrow,
    input  logic [VALUE_BITS-1:0] i_moved_val,
    input  logic                  i_best_valid,
    input  logic [VALUE_BITS-1:0] i_best_val,
    input  logic [POS_BITS-1:0]   i_best_pos,
    input  logic                  i_best_arrow,
    output logic [VALUE_BITS-1:0] o_val,
    output logic                  o_arrow,
    output logic                  o_best_valid,
    output logic [VALUE_BITS-1:0] o_best_val,
    output logic [POS_BITS-1:0]   o_best_pos,
    output logic                  o_best_arrow
);
    import jtp_pkg::*;

    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_arrow, n_arrow;
    logic                  r_best_valid, n_best_valid;
    logic [VALUE_BITS-1:0] r_best_val, n_best_val;
    logic [POS_BITS-1:0]   r_best_pos, n_best_pos;
    logic                  r_best_arrow, n_best_arrow;
    logic                  w_mobile;

    // mobile: arrow points at an in-range smaller neighbor
    assign w_mobile = r_arrow ? (i_cmd.active_right && (r_val > i_right_val))
                              : (i_cmd.active && i_cmd.has_left && (r_val > i_left_val));

    // scan stage: keep the incoming candidate unless this cell is mobile and strictly larger, or none is valid
    always_comb begin
        if (w_mobile && (!i_best_valid || (r_val > i_best_val))) begin
            n_best_valid = 1'b1;
            n_best_val   = r_val;
            n_best_pos   = POS_BITS'(CELL_INDEX);
            n_best_arrow = r_arrow;
        end else begin
            n_best_valid = i_best_valid;
            n_best_val   = i_best_val;
            n_best_pos   = i_best_pos;
            n_best_arrow = i_best_arrow;
        end
    end

    // load, swap with a neighbor, then flip arrows of larger values
    always_comb begin
        if (i_cmd.load) begin
            n_val   = i_load_val;
            n_arrow = i_load_arrow;
        end else if (i_cmd.take_right) begin
            n_val   = i_right_val;
            n_arrow = i_right_arrow;
        end else if (i_cmd.take_left) begin
            n_val   = i_left_val;
            n_arrow = i_left_arrow;
        end else begin
            n_val   = r_val;
            n_arrow = r_arrow;
        end
        if (i_cmd.update && (n_val > i_moved_val)) begin
            n_arrow = ~n_arrow;
        end
    end

    // element storage
    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_arrow <= n_arrow;
    end

    // scan stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
        end else begin
            r_best_valid <= n_best_valid;
        end
        r_best_val   <= n_best_val;
        r_best_pos   <= n_best_pos;
        r_best_arrow <= n_best_arrow;
    end

    assign o_val        = r_val;
    assign o_arrow      = r_arrow;
    assign o_best_valid = r_best_valid;
    assign o_best_val   = r_best_val;
    assign o_best_pos   = r_best_pos;
    assign o_best_arrow = r_best_arrow;

endmodule

// ----- rtl/core/johnson_trotter_permutation_step.sv -----
// top level: sequencer, register port and cell chain of the permutation step
//
// Usage
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. A load item (func 0) writes one position's value and arrow at that
//   edge and leaves busy low, so loads may follow back to back. A step item
//   (func 1) raises busy until its results are out.
//   Results: a step reports every active position, lowest first, one item per
//   cycle with o_strobe high for exactly that cycle; last marks the final one.
//   The receiver cannot stall; results are always taken.
//   Sequence: a step runs a scan, the swap, a second scan and then the report.
//   The two scans walk a candidate down the whole cell chain, one cell per
//   cycle, before and after the swap; output then reads one position per cycle.
//   busy drops with the last result on the ports, so the next item may enter.
//   Configuration: active_length at byte address 0 over the APB-style port, to be
//   written only while busy is low (not enforced by the block); pready is always high.
//   Reset: synchronous, active low; active_length returns to 8 and the
//   sequencer idles. Element storage is undefined until loaded.
module johnson_trotter_permutation_step #(
    parameter int MAX_LENGTH = 8,
    parameter int VALUE_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  jtp_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output jtp_pkg::t_out_item  o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import jtp_pkg::*;

    localparam int PW = $clog2(MAX_LENGTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);

    t_state                r_state, n_state;
    logic [PW-1:0]         r_cnt, n_cnt;
    logic                  r_moved;
    logic [3:0]            r_active_length;
    logic                  r_strobe;
    t_out_item             r_result, n_result;

    logic [LW-1:0]         w_len;
    logic [MAX_LENGTH-1:0] w_act;
    logic                  w_load_go;
    logic                  w_step_go;
    logic                  w_scan_done;
    logic                  w_emit_last;
    logic                  w_swap_go;
    logic [PW-1:0]         w_lo;
    logic [VALUE_BITS-1:0] w_load_val;
    logic [VALUE_BITS+7:0] w_load_wide;
    logic [VALUE_BITS+7:0] w_out_wide;

    logic [VALUE_BITS-1:0] w_val   [MAX_LENGTH];
    logic                  w_arrow [MAX_LENGTH];
    logic                  w_bv    [MAX_LENGTH];
    logic [VALUE_BITS-1:0] w_bval  [MAX_LENGTH];
    logic [PW-1:0]         w_bpos  [MAX_LENGTH];
    logic                  w_barrow[MAX_LENGTH];
    t_cell_cmd             w_cmd   [MAX_LENGTH];

    // configuration register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= ACTIVE_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_LENGTH)) begin
            r_active_length <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_LENGTH) ? {28'd0, r_active_length} : 32'd0;

    // effective length, clamped to 1..MAX_LENGTH
    always_comb begin
        if (r_active_length == 4'd0) begin
            w_len = LW'(1);
        end else if (int'(r_active_length) > MAX_LENGTH) begin
            w_len = LW'(MAX_LENGTH);
        end else begin
            w_len = LW'(r_active_length);
        end
    end

    // item decode
    assign w_load_go   = start && !busy && (i_item.func == FUNC_LOAD);
    assign w_step_go   = start && !busy && (i_item.func == FUNC_STEP);
    assign w_scan_done = (r_cnt == PW'(MAX_LENGTH - 1));
    assign w_emit_last = ((LW'(r_cnt) + LW'(1)) == w_len);

    // load value resized to the element width
    assign w_load_wide = {{VALUE_BITS{1'b0}}, i_item.elem_value};
    assign w_load_val  = w_load_wide[VALUE_BITS-1:0];

    // winner of the scan comes out of the last cell
    assign w_swap_go = (r_state == ST_SWAP) && w_bv[MAX_LENGTH-1];
    assign w_lo      = w_barrow[MAX_LENGTH-1] ? w_bpos[MAX_LENGTH-1]
                                              : (w_bpos[MAX_LENGTH-1] - PW'(1));

    // cell chain
    for (genvar i = 0; i < MAX_LENGTH; i++) begin : g_cell
        logic [VALUE_BITS-1:0] w_lv, w_rv;
        logic                  w_la, w_ra;
        logic                  w_in_valid;
        logic [VALUE_BITS-1:0] w_in_val;
        logic [PW-1:0]         w_in_pos;
        logic                  w_in_arrow;

        assign w_act[i] = (i < int'(w_len));

        if (i == 0) begin : g_first
            assign w_lv       = '0;
            assign w_la       = 1'b0;
            assign w_in_valid = 1'b0;
            assign w_in_val   = '0;
            assign w_in_pos   = '0;
            assign w_in_arrow = 1'b0;
            assign w_cmd[i].take_left = 1'b0;
            assign w_cmd[i].has_left  = 1'b0;
        end else begin : g_inner
            assign w_lv       = w_val[i-1];
            assign w_la       = w_arrow[i-1];
            assign w_in_valid = w_bv[i-1];
            assign w_in_val   = w_bval[i-1];
            assign w_in_pos   = w_bpos[i-1];
            assign w_in_arrow = w_barrow[i-1];
            assign w_cmd[i].take_left = w_swap_go && (w_lo == PW'(i - 1));
            assign w_cmd[i].has_left  = 1'b1;
        end

        if (i == MAX_LENGTH - 1) begin : g_end
            assign w_rv = '0;
            assign w_ra = 1'b0;
            assign w_cmd[i].active_right = 1'b0;
        end else begin : g_mid
            assign w_rv = w_val[i+1];
            assign w_ra = w_arrow[i+1];
            assign w_cmd[i].active_right = w_act[i+1];
        end

        assign w_cmd[i].load       = w_load_go && (int'(i_item.position) == i);
        assign w_cmd[i].take_right = w_swap_go && (w_lo == PW'(i));
        assign w_cmd[i].update     = w_swap_go && w_act[i];
        assign w_cmd[i].active     = w_act[i];

        jtp_cell #(
            .VALUE_BITS (VALUE_BITS),
            .POS_BITS   (PW),
            .CELL_INDEX (i)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd[i]),
            .i_load_val    (w_load_val),
            .i_load_arrow  (i_item.arrow_right),
            .i_left_val    (w_lv),
            .i_left_arrow  (w_la),
            .i_right_val   (w_rv),
            .i_right_arrow (w_ra),
            .i_moved_val   (w_bval[MAX_LENGTH-1]),
            .i_best_valid  (w_in_valid),
            .i_best_val    (w_in_val),
            .i_best_pos    (w_in_pos),
            .i_best_arrow  (w_in_arrow),
            .o_val         (w_val[i]),
            .o_arrow       (w_arrow[i]),
            .o_best_valid  (w_bv[i]),
            .o_best_val    (w_bval[i]),
            .o_best_pos    (w_bpos[i]),
            .o_best_arrow  (w_barrow[i])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_step_go) begin
                    n_state = ST_SCAN_PRE;
                end
            end
            ST_SCAN_PRE: begin
                if (w_scan_done) begin
                    n_state = ST_SWAP;
                end
            end
            ST_SWAP: begin
                n_state = ST_SCAN_POST;
            end
            ST_SCAN_POST: begin
                if (w_scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: busy and the cycle counter
    always_comb begin
        busy  = (r_state != ST_IDLE);
        n_cnt = '0;
        case (r_state)
            ST_SCAN_PRE, ST_SCAN_POST: begin
                n_cnt = w_scan_done ? '0 : (r_cnt + PW'(1));
            end
            ST_EMIT: begin
                n_cnt = w_emit_last ? '0 : (r_cnt + PW'(1));
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // swap outcome, held for the whole report
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SWAP) begin
            r_moved <= w_bv[MAX_LENGTH-1];
        end
    end

    // result item for the position under the counter
    assign w_out_wide = {8'd0, w_val[r_cnt]};
    always_comb begin
        n_result.out_position    = 3'(r_cnt);
        n_result.out_value       = w_out_wide[7:0];
        n_result.out_arrow_right = w_arrow[r_cnt];
        n_result.moved           = r_moved;
        n_result.mobile_remains  = w_bv[MAX_LENGTH-1];
        n_result.last            = w_emit_last;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_EMIT);
        end
        if (r_state == ST_EMIT) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // a result only follows a report cycle
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EMIT))
        else $error("result strobe without a report cycle");

    // a report runs without gaps until its last position
    a_report_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("gap inside a report");

    // moved flag is the same on every position of a report
    a_moved_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && !$past(o_result.last))
            |-> (o_result.moved == $past(o_result.moved)))
        else $error("moved flag changed within a report");

    // the second scan starts from the head of the chain
    a_rescan_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWAP) |=> ((r_state == ST_SCAN_POST) && (r_cnt == '0)))
        else $error("rescan did not start at cell zero");

endmodule

// ----- tb/johnson_trotter_permutation_step_tb.sv -----
// self-checking bench for the permutation step block: directed table, then random walks
module johnson_trotter_permutation_step_tb;
    import jtp_pkg::*;

    localparam int MAX_POS = 8;
    // accept to last result of a step, plus a little slack
    localparam int STEP_LATENCY = 2 * MAX_POS + 1 + MAX_POS + 4;
    localparam logic REG_UNMAPPED = 1'b1;

    typedef enum {ROW_LOAD, ROW_STEP, ROW_WRITE} t_row_kind;

    // one line of the directed table; flags are typed in only where obvious
    typedef struct {
        t_row_kind  kind;
        logic [2:0] pos;
        logic [7:0] data;
        logic       arrow;
        logic       reg_idx;
        bit         typed;
        bit         t_moved;
        bit         t_remains;
    } t_dir_row;

    localparam int DIR_ROWS = 27;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // standard start: values in order, every arrow left
        '{ROW_LOAD, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 1, 1, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 2, 2, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 3, 3, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 4, 4, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 5, 5, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 6, 6, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 7, 7, 0, 0, 0, 0, 0},
        '{ROW_STEP, 0, 0, 0, 0, 1, 1, 1},
        '{ROW_STEP, 0, 0, 0, 0, 1, 1, 1},
        // single position: nothing can move
        '{ROW_WRITE, 0, 1, 0, REG_ACTIVE_LENGTH, 0, 0, 0},
        '{ROW_STEP, 0, 0, 0, 0, 1, 0, 0},
        // zero length acts as one
        '{ROW_WRITE, 0, 0, 0, REG_ACTIVE_LENGTH, 0, 0, 0},
        '{ROW_STEP, 0, 0, 0, 0, 1, 0, 0},
        // length above the maximum acts as the maximum; tie between two 200s
        '{ROW_WRITE, 0, 15, 0, REG_ACTIVE_LENGTH, 0, 0, 0},
        '{ROW_LOAD, 0, 200, 1, 0, 0, 0, 0},
        '{ROW_LOAD, 1, 5, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 2, 200, 0, 0, 0, 0, 0},
        '{ROW_LOAD, 7, 255, 1, 0, 0, 0, 0},
        '{ROW_STEP, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_STEP, 0, 0, 0, 0, 0, 0, 0},
        // two positions with no mobile value; unmapped write must not matter
        '{ROW_WRITE, 0, 2, 0, REG_ACTIVE_LENGTH, 0, 0, 0},
        '{ROW_WRITE, 0, 5, 0, REG_UNMAPPED, 0, 0, 0},
        '{ROW_LOAD, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_LOAD, 1, 255, 1, 0, 0, 0, 0},
        '{ROW_STEP, 0, 0, 0, 0, 1, 0, 0},
        '{ROW_STEP, 0, 0, 0, 0, 1, 0, 0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_strobe;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // permutation and register copy kept by the bench
    logic [7:0] perm_val [MAX_POS];
    logic       perm_arw [MAX_POS];
    logic [3:0] len_reg = ACTIVE_LENGTH_RESET;
    t_out_item  pending_results [$];

    // typed flags for the item now on the command port
    bit chk_flags = 1'b0;
    bit chk_moved = 1'b0;
    bit chk_remains = 1'b0;

    int idle_pct = 0;
    int items_sent = 0;
    int mismatch_count = 0;
    t_out_item want;

    johnson_trotter_permutation_step #(
        .MAX_LENGTH(MAX_POS),
        .VALUE_BITS(8)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, exp_val);
    endtask

    // length in effect: zero acts as one, above the maximum clamps
    function automatic int live_length();
        if (len_reg == 4'd0) return 1;
        if (int'(len_reg) > MAX_POS) return MAX_POS;
        return int'(len_reg);
    endfunction

    // mobile: arrow points at an in-range, strictly smaller neighbor
    function automatic bit can_move(input int i, input int n);
        if (perm_arw[i]) return (i + 1 < n) && (perm_val[i] > perm_val[i + 1]);
        return (i > 0) && (perm_val[i] > perm_val[i - 1]);
    endfunction

    // largest mobile value, lowest position on ties, n when none
    function automatic int top_mobile_pos(input int n);
        int best;
        best = n;
        for (int i = 0; i < n; i++)
            if (can_move(i, n) && (best == n || perm_val[i] > perm_val[best])) best = i;
        return best;
    endfunction

    // apply one item to the bench copy and queue the positions it reports
    function automatic void predict_item(input t_in_item it, input bit use_flags,
                                         input bit f_moved, input bit f_remains);
        int n;
        int k;
        int dst;
        logic [7:0] mv;
        logic [7:0] tv;
        logic ta;
        bit did_move;
        bit still;
        t_out_item r;
        if (it.func == FUNC_LOAD) begin
            perm_val[it.position] = it.elem_value;
            perm_arw[it.position] = it.arrow_right;
            return;
        end
        n = live_length();
        k = top_mobile_pos(n);
        did_move = 1'b0;
        if (k < n) begin
            did_move = 1'b1;
            mv = perm_val[k];
            dst = perm_arw[k] ? k + 1 : k - 1;
            tv = perm_val[dst];
            ta = perm_arw[dst];
            perm_val[dst] = perm_val[k];
            perm_arw[dst] = perm_arw[k];
            perm_val[k] = tv;
            perm_arw[k] = ta;
            for (int i = 0; i < n; i++)
                if (perm_val[i] > mv) perm_arw[i] = ~perm_arw[i];
        end
        still = (top_mobile_pos(n) < n);
        if (use_flags) begin
            did_move = f_moved;
            still = f_remains;
        end
        for (int i = 0; i < n; i++) begin
            r.out_position = 3'(i);
            r.out_value = perm_val[i];
            r.out_arrow_right = perm_arw[i];
            r.moved = did_move;
            r.mobile_remains = still;
            r.last = (i == n - 1);
            pending_results.insert(pending_results.size(), r);
        end
    endfunction

    // result checking and item capture at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", int'(o_result), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.out_position !== want.out_position)
                        report_mismatch("out_position", o_result.out_position,
                                        want.out_position);
                    if (o_result.out_value !== want.out_value)
                        report_mismatch("out_value", o_result.out_value, want.out_value);
                    if (o_result.out_arrow_right !== want.out_arrow_right)
                        report_mismatch("out_arrow_right", o_result.out_arrow_right,
                                        want.out_arrow_right);
                    if (o_result.moved !== want.moved)
                        report_mismatch("moved", o_result.moved, want.moved);
                    if (o_result.mobile_remains !== want.mobile_remains)
                        report_mismatch("mobile_remains", o_result.mobile_remains,
                                        want.mobile_remains);
                    if (o_result.last !== want.last)
                        report_mismatch("last", o_result.last, want.last);
                end
            end
            if (start && !busy) predict_item(i_item, chk_flags, chk_moved, chk_remains);
        end
    end

    // drive one item after random idle cycles, return once it is taken
    task automatic send_item(input t_in_item it, input bit typed,
                             input bit t_moved, input bit t_remains);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        chk_flags = typed;
        chk_moved = t_moved;
        chk_remains = t_remains;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // register write over the bus, only once the block has gone quiet
    task automatic write_register(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (STEP_LATENCY) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_ACTIVE_LENGTH) len_reg = data[3:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // item with every field random apart from the function
    function automatic t_in_item rand_item(input logic func);
        t_in_item it;
        it.func = func;
        it.position = 3'($urandom_range(7));
        it.elem_value = 8'($urandom_range(255));
        it.arrow_right = 1'($urandom_range(1));
        return it;
    endfunction

    // random part: mostly load-a-permutation-then-walk, some noise
    task automatic run_random(input int quota);
        int stop_at;
        int n;
        int j;
        int steps;
        logic [7:0] vals [MAX_POS];
        logic [7:0] tmp;
        logic [31:0] wdata;
        bit plain_arrows;
        t_in_item it;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(1) == 1) begin
                wdata = $urandom();
                wdata[3:0] = 4'($urandom_range(15));
                write_register(REG_ACTIVE_LENGTH, wdata);
            end
            n = live_length();
            if ($urandom_range(9) < 7) begin
                // distinct ascending values, sometimes shuffled
                vals[0] = 8'($urandom_range(45));
                for (int i = 1; i < MAX_POS; i++)
                    vals[i] = vals[i - 1] + 8'($urandom_range(1, 30));
                if ($urandom_range(9) < 3) begin
                    for (int i = n - 1; i > 0; i--) begin
                        j = $urandom_range(i);
                        tmp = vals[i];
                        vals[i] = vals[j];
                        vals[j] = tmp;
                    end
                end
                plain_arrows = ($urandom_range(9) < 7);
                for (int i = 0; i < n; i++) begin
                    it.func = FUNC_LOAD;
                    it.position = 3'(i);
                    it.elem_value = vals[i];
                    it.arrow_right = plain_arrows ? 1'b0 : 1'($urandom_range(1));
                    send_item(it, 1'b0, 1'b0, 1'b0);
                end
                steps = $urandom_range(1, 30);
                repeat (steps) send_item(rand_item(FUNC_STEP), 1'b0, 1'b0, 1'b0);
            end else begin
                // noise: stray loads anywhere, duplicates allowed, and steps
                repeat (6) send_item(rand_item(1'($urandom_range(1))), 1'b0, 1'b0, 1'b0);
            end
        end
    endtask

    // main sequence
    initial begin
        int wait_cycles;
        t_in_item it;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 14;
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE: begin
                    write_register(dir_rows[i].reg_idx, 32'(dir_rows[i].data));
                end
                ROW_LOAD: begin
                    it.func = FUNC_LOAD;
                    it.position = dir_rows[i].pos;
                    it.elem_value = dir_rows[i].data;
                    it.arrow_right = dir_rows[i].arrow;
                    send_item(it, 1'b0, 1'b0, 1'b0);
                end
                default: begin
                    it = '0;
                    it.func = FUNC_STEP;
                    send_item(it, dir_rows[i].typed, dir_rows[i].t_moved,
                              dir_rows[i].t_remains);
                end
            endcase
        end
        run_random(150);

        idle_pct = 79;
        run_random(150);

        idle_pct = 0;
        run_random(150);

        // drain
        @(negedge i_clk);
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 10 * STEP_LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (STEP_LATENCY) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- johnson_trotter_permutation_step.f -----
rtl/core/jtp_pkg.sv
rtl/core/jtp_cell.sv
rtl/core/johnson_trotter_permutation_step.sv
tb/johnson_trotter_permutation_step_tb.sv
